// ===== rtl/clit_pkg.sv =====
// Shared types and constants for the core-local interrupt timer.
// Used by every module of the block; depends on nothing.
package clit_pkg;

    localparam int CLIT_NUM_HARTS = 8;
    localparam int CLIT_DATA_W    = 64;
    localparam int CLIT_OFFSET_W  = 16;
    localparam int CLIT_IRQ_W     = 8;

    // Register map
    localparam logic [CLIT_OFFSET_W-1:0] CLIT_MSIP_BASE   = 16'h0000;
    localparam logic [CLIT_OFFSET_W-1:0] CLIT_CMP_BASE    = 16'h4000;
    localparam logic [CLIT_OFFSET_W-1:0] CLIT_TIME_OFFSET = 16'hbff8;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_SOFT = 2'd1,
        KIND_CMP  = 2'd2,
        KIND_TIME = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_EVAL = 2'd2
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic eval;
    } ctrl_cmd_t;

endpackage

// ===== rtl/clit_ctrl.sv =====
// Sequencer of the core-local interrupt timer: load, execute, evaluate.
// Depends on clit_pkg.
module clit_ctrl
    import clit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXEC;
            end
            ST_EXEC: state_next = ST_EVAL;
            ST_EVAL: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd       = '0;
        done_next = 1'b0;
        case (state_reg)
            ST_IDLE: cmd.load = start;
            ST_EXEC: cmd.exec = 1'b1;
            ST_EVAL:
            begin
                cmd.eval  = 1'b1;
                done_next = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ===== rtl/clit_datapath.sv =====
// Datapath of the core-local interrupt timer: time counter, compare and
// software-pending registers, address decode and interrupt lines. Depends on clit_pkg.
module clit_datapath
    import clit_pkg::*;
#(
    parameter int NUM_HARTS = CLIT_NUM_HARTS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd,
    input  logic [1:0]               command,
    input  logic [CLIT_OFFSET_W-1:0] offset,
    input  logic [CLIT_DATA_W-1:0]   write_data,
    output logic [CLIT_DATA_W-1:0]   read_data,
    output logic                     access_error,
    output logic [CLIT_IRQ_W-1:0]    soft_irq,
    output logic [CLIT_IRQ_W-1:0]    timer_irq
);

    localparam int HART_W    = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
    localparam int SOFT_END  = 4 * NUM_HARTS;
    localparam int CMP_END   = 16'h4000 + 8 * NUM_HARTS;

    // Captured input word
    logic [1:0]               command_reg;
    logic [CLIT_OFFSET_W-1:0] offset_reg;
    logic [CLIT_DATA_W-1:0]   write_data_reg;

    // Architectural state
    logic [CLIT_DATA_W-1:0]   time_reg;
    logic [CLIT_DATA_W-1:0]   time_next;
    logic [CLIT_DATA_W-1:0]   cmp_reg  [NUM_HARTS];
    logic [CLIT_DATA_W-1:0]   cmp_next [NUM_HARTS];
    logic [NUM_HARTS-1:0]     soft_reg;
    logic [NUM_HARTS-1:0]     soft_next;

    // Result registers
    logic [CLIT_DATA_W-1:0]   read_data_reg;
    logic [CLIT_DATA_W-1:0]   read_data_next;
    logic                     access_error_reg;
    logic                     access_error_next;
    logic [CLIT_IRQ_W-1:0]    soft_irq_reg;
    logic [CLIT_IRQ_W-1:0]    soft_irq_next;
    logic [CLIT_IRQ_W-1:0]    timer_irq_reg;
    logic [CLIT_IRQ_W-1:0]    timer_irq_next;

    kind_t                    kind;
    logic [HART_W-1:0]        hart;

    // Hold the input word for the whole item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg    <= command;
            offset_reg     <= offset;
            write_data_reg <= write_data;
        end
    end

    // Decode the offset into register kind and hart index
    always_comb
    begin
        kind = KIND_NONE;
        hart = '0;
        if (offset_reg == CLIT_TIME_OFFSET)
            kind = KIND_TIME;
        else if (offset_reg >= CLIT_CMP_BASE
                 && {1'b0, offset_reg} < 17'(CMP_END)
                 && offset_reg[2:0] == 3'b000)
        begin
            kind = KIND_CMP;
            hart = offset_reg[HART_W+2:3];
        end
        else if ({1'b0, offset_reg} < 17'(SOFT_END)
                 && offset_reg[1:0] == 2'b00)
        begin
            kind = KIND_SOFT;
            hart = offset_reg[HART_W+1:2];
        end
    end

    // Apply tick, read or write
    always_comb
    begin
        time_next         = time_reg;
        soft_next         = soft_reg;
        read_data_next    = read_data_reg;
        access_error_next = access_error_reg;
        for (int i = 0; i < NUM_HARTS; i++)
            cmp_next[i] = cmp_reg[i];
        if (cmd.exec)
        begin
            read_data_next    = '0;
            access_error_next = 1'b0;
            case (command_reg)
                CMD_TICK: time_next = time_reg + 64'd1;
                CMD_READ:
                begin
                    case (kind)
                        KIND_SOFT: read_data_next = {63'd0, soft_reg[hart]};
                        KIND_CMP:  read_data_next = cmp_reg[hart];
                        KIND_TIME: read_data_next = time_reg;
                        default:   access_error_next = 1'b1;
                    endcase
                end
                CMD_WRITE:
                begin
                    case (kind)
                        KIND_SOFT: soft_next[hart] = write_data_reg[0];
                        KIND_CMP:  cmp_next[hart] = write_data_reg;
                        KIND_TIME: time_next = write_data_reg;
                        default:   access_error_next = 1'b1;
                    endcase
                end
                default: read_data_next = '0;
            endcase
        end
    end

    // Evaluate interrupt lines from the updated state
    always_comb
    begin
        soft_irq_next  = soft_irq_reg;
        timer_irq_next = timer_irq_reg;
        if (cmd.eval)
        begin
            soft_irq_next  = '0;
            timer_irq_next = '0;
            for (int i = 0; i < CLIT_IRQ_W; i++)
            begin
                if (i < NUM_HARTS)
                begin
                    soft_irq_next[i]  = soft_reg[i];
                    timer_irq_next[i] = (time_reg >= cmp_reg[i]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg         <= '0;
            soft_reg         <= '0;
            read_data_reg    <= '0;
            access_error_reg <= 1'b0;
            soft_irq_reg     <= '0;
            timer_irq_reg    <= '0;
            for (int i = 0; i < NUM_HARTS; i++)
                cmp_reg[i] <= '1;
        end
        else
        begin
            time_reg         <= time_next;
            soft_reg         <= soft_next;
            read_data_reg    <= read_data_next;
            access_error_reg <= access_error_next;
            soft_irq_reg     <= soft_irq_next;
            timer_irq_reg    <= timer_irq_next;
            for (int i = 0; i < NUM_HARTS; i++)
                cmp_reg[i] <= cmp_next[i];
        end
    end

    assign read_data    = read_data_reg;
    assign access_error = access_error_reg;
    assign soft_irq     = soft_irq_reg;
    assign timer_irq    = timer_irq_reg;

endmodule

// ===== rtl/core_local_interrupt_timer.sv =====
// Core-local interrupt timer: one 64-bit time counter, per-hart compare and
// software-interrupt words. Each word passes the load, execute and evaluate steps
// of the sequencer before its result is taken (done); a new word is accepted only
// while busy is low. The receiver cannot stall.
// Reset (rst_n low, asynchronous) clears time and pending bits, sets compares to all ones.
module core_local_interrupt_timer
    import clit_pkg::*;
#(
    parameter int NUM_HARTS = CLIT_NUM_HARTS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               command,
    input  logic [CLIT_OFFSET_W-1:0] offset,
    input  logic [CLIT_DATA_W-1:0]   write_data,
    output logic                     done,
    output logic [CLIT_DATA_W-1:0]   read_data,
    output logic                     access_error,
    output logic [CLIT_IRQ_W-1:0]    soft_irq,
    output logic [CLIT_IRQ_W-1:0]    timer_irq
);

    ctrl_cmd_t cmd;

    // Sequence each word
    clit_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Hold registers and compute results
    clit_datapath #(
        .NUM_HARTS (NUM_HARTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .command      (command),
        .offset       (offset),
        .write_data   (write_data),
        .read_data    (read_data),
        .access_error (access_error),
        .soft_irq     (soft_irq),
        .timer_irq    (timer_irq)
    );

endmodule

// ===== rtl/clit_checker.sv =====
// Port-level checks for the core-local interrupt timer, bound to the top level.
// Depends on clit_pkg and core_local_interrupt_timer.
module clit_checker
    import clit_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic [CLIT_DATA_W-1:0]   read_data,
    input logic                     access_error
);

    // An accepted word yields its result strobe after the execute and evaluate states
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing three cycles after accept");

    // Busy rises right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // The strobe ends the work: block is free while it shows
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside end of work");

    // An error result never carries read data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && access_error) |-> (read_data == '0))
        else $error("error result with non-zero read data");

endmodule

bind core_local_interrupt_timer clit_checker u_clit_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .read_data    (read_data),
    .access_error (access_error)
);
